[design/sscp_pkg.sv]
package sscp_pkg;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned VEC_W  = 33;
  localparam int unsigned SV_W   = 32;
  localparam int unsigned DOT_W  = 64;
  localparam int unsigned WIDE_W = 128;
  localparam int unsigned DIST_W = 33;
  localparam int unsigned PD_W   = 37;
  localparam int unsigned SUM_W  = 76;
  localparam int unsigned ROOT_W = 38;

  localparam logic [ROOT_W-1:0] DIST_MAX = 38'h1_FFFF_FFFF;
  localparam logic signed [VEC_W-1:0] LIM30 = 33'sd1073741824;

  typedef logic [11:0][IN_W-1:0] pts_t;
  typedef logic [8:0][VEC_W-1:0] vecs_t;

  typedef struct packed {
    logic [DOT_W-1:0]  a;
    logic [DOT_W-1:0]  b;
    logic [DOT_W-1:0]  c;
    logic [DOT_W-1:0]  d;
    logic [DOT_W-1:0]  e;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
    vecs_t             vec;
    logic              uz;
    logic              vz;
  } front_t;

endpackage

[design/sscp_delay.sv]
module sscp_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[D-1];

endmodule

[design/sscp_qdiv.sv]
module sscp_qdiv #(
  parameter int unsigned W  = 128,
  parameter int unsigned FB = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic [FB:0]         q_o
);

  logic [W-1:0]  rem_q  [FB+1];
  logic [W-1:0]  den_q  [FB+1];
  logic [FB-1:0] qb_q   [FB+1];
  logic          zero_q [FB+1];
  logic          sat_q  [FB+1];

  // clamp decision, then one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (num_i <= 0);
      sat_q[0]  <= (num_i >= den_i);
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      qb_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [W:0] rem2;
    logic       ge;
    assign rem2 = {rem_q[k-1], 1'b0};
    assign ge   = (rem2 >= {1'b0, den_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? W'(rem2 - {1'b0, den_q[k-1]}) : W'(rem2);
        den_q[k]  <= den_q[k-1];
        qb_q[k]   <= {qb_q[k-1][FB-2:0], ge};
        zero_q[k] <= zero_q[k-1];
        sat_q[k]  <= sat_q[k-1];
      end
    end
  end

  assign q_o = zero_q[FB] ? '0 :
               sat_q[FB]  ? {1'b1, {FB{1'b0}}} : {1'b0, qb_q[FB]};

endmodule

[design/sscp_isqrt.sv]
module sscp_isqrt #(
  parameter int unsigned SW = 76,
  parameter int unsigned RW = 38
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] sum_i,
  output logic [RW-1:0] root_o
);

  localparam int unsigned QW = SW + 2;

  logic [RW-1:0] root_q [RW+1];
  logic [QW-1:0] sq_q   [RW+1];
  logic [SW-1:0] sum_q  [RW+1];

  assign root_q[0] = '0;
  assign sq_q[0]   = '0;
  assign sum_q[0]  = sum_i;

  // bit i of the root per stage, square kept incrementally
  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int unsigned BI = RW - 1 - k;
    logic [QW-1:0] cand_sq;
    logic          take;
    assign cand_sq = sq_q[k] + (QW'(root_q[k]) << (BI + 1)) + (QW'(1) << (2 * BI));
    assign take    = (cand_sq <= QW'(sum_q[k]));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k+1] <= take ? (root_q[k] | (RW'(1) << BI)) : root_q[k];
        sq_q[k+1]   <= take ? cand_sq : sq_q[k];
        sum_q[k+1]  <= sum_q[k];
      end
    end
  end

  assign root_o = root_q[RW];

endmodule

[design/sscp_front.sv]
module sscp_front (
  input  logic             clk_i,
  input  logic             en_i,
  input  sscp_pkg::pts_t   pts_i,
  output sscp_pkg::front_t res_o
);

  import sscp_pkg::*;

  localparam int unsigned HW   = DOT_W / 2;
  localparam int unsigned PP_W = DOT_W + 2;

  function automatic logic signed [HW:0] hi_part(logic signed [DOT_W-1:0] x);
    return {x[DOT_W-1], x[DOT_W-1:HW]};
  endfunction

  function automatic logic signed [HW:0] lo_part(logic signed [DOT_W-1:0] x);
    return {1'b0, x[HW-1:0]};
  endfunction

  function automatic logic signed [PP_W-1:0] pmul(logic signed [HW:0] x,
                                                  logic signed [HW:0] y);
    return x * y;
  endfunction

  function automatic logic signed [WIDE_W-1:0] pjoin(logic signed [PP_W-1:0] hh,
                                                     logic signed [PP_W-1:0] hl,
                                                     logic signed [PP_W-1:0] lh,
                                                     logic signed [PP_W-1:0] ll);
    return (WIDE_W'(hh) <<< (2 * HW)) + ((WIDE_W'(hl) + WIDE_W'(lh)) <<< HW)
           + WIDE_W'(ll);
  endfunction

  logic signed [VEC_W-1:0] vec_c [9];
  logic signed [VEC_W-1:0] sh1_c [9];
  logic signed [VEC_W-1:0] sh2_c [9];
  logic                    fit0_c, fit1_c, uz_c, vz_c;

  logic signed [SV_W-1:0]   sv1_q [9];
  logic signed [DOT_W-1:0]  pr2_q [15];
  logic signed [DOT_W-1:0]  a3_q, b3_q, c3_q, d3_q, e3_q;
  logic signed [DOT_W-1:0]  a4_q, b4_q, c4_q, d4_q, e4_q;
  logic signed [DOT_W-1:0]  a5_q, b5_q, c5_q, d5_q, e5_q;
  logic signed [DOT_W-1:0]  mx_c [4];
  logic signed [DOT_W-1:0]  my_c [4];
  logic signed [PP_W-1:0]   pp4_q [16];
  logic signed [WIDE_W-1:0] ac5_q, bb5_q, dc5_q, eb5_q;
  vecs_t                    vec1_q, vec2_q, vec3_q, vec4_q, vec5_q;
  logic                     uz1_q, vz1_q, uz2_q, vz2_q, uz3_q, vz3_q, uz4_q, vz4_q;
  logic                     uz5_q, vz5_q;
  front_t                   res_q;

  // differences and a common scale that keeps the solve inside 31 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec_c[i]   = $signed({pts_i[3+i][IN_W-1], pts_i[3+i]})
                 - $signed({pts_i[i][IN_W-1], pts_i[i]});
      vec_c[3+i] = $signed({pts_i[9+i][IN_W-1], pts_i[9+i]})
                 - $signed({pts_i[6+i][IN_W-1], pts_i[6+i]});
      vec_c[6+i] = $signed({pts_i[6+i][IN_W-1], pts_i[6+i]})
                 - $signed({pts_i[i][IN_W-1], pts_i[i]});
    end
    fit0_c = 1'b1;
    fit1_c = 1'b1;
    for (int i = 0; i < 9; i++) begin
      sh1_c[i] = vec_c[i] >>> 1;
      sh2_c[i] = vec_c[i] >>> 2;
      if (vec_c[i] > LIM30 || vec_c[i] < -LIM30) fit0_c = 1'b0;
      if (sh1_c[i] > LIM30 || sh1_c[i] < -LIM30) fit1_c = 1'b0;
    end
    uz_c = (vec_c[0] == 0) && (vec_c[1] == 0) && (vec_c[2] == 0);
    vz_c = (vec_c[3] == 0) && (vec_c[4] == 0) && (vec_c[5] == 0);
  end

  // operand pairs of the wide products
  assign mx_c = '{a3_q, b3_q, d3_q, e3_q};
  assign my_c = '{c3_q, b3_q, c3_q, b3_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        vec1_q[i] <= vec_c[i];
        sv1_q[i]  <= fit0_c ? SV_W'(vec_c[i]) : fit1_c ? SV_W'(sh1_c[i]) : SV_W'(sh2_c[i]);
      end
      uz1_q <= uz_c;
      vz1_q <= vz_c;

      for (int i = 0; i < 3; i++) begin
        pr2_q[i]    <= sv1_q[i] * sv1_q[i];
        pr2_q[3+i]  <= sv1_q[i] * sv1_q[3+i];
        pr2_q[6+i]  <= sv1_q[3+i] * sv1_q[3+i];
        pr2_q[9+i]  <= sv1_q[i] * sv1_q[6+i];
        pr2_q[12+i] <= sv1_q[3+i] * sv1_q[6+i];
      end
      vec2_q <= vec1_q;
      uz2_q  <= uz1_q;
      vz2_q  <= vz1_q;

      a3_q   <= pr2_q[0] + pr2_q[1] + pr2_q[2];
      b3_q   <= pr2_q[3] + pr2_q[4] + pr2_q[5];
      c3_q   <= pr2_q[6] + pr2_q[7] + pr2_q[8];
      d3_q   <= pr2_q[9] + pr2_q[10] + pr2_q[11];
      e3_q   <= pr2_q[12] + pr2_q[13] + pr2_q[14];
      vec3_q <= vec2_q;
      uz3_q  <= uz2_q;
      vz3_q  <= vz2_q;

      // half-word partial products
      for (int j = 0; j < 4; j++) begin
        pp4_q[4*j]   <= pmul(hi_part(mx_c[j]), hi_part(my_c[j]));
        pp4_q[4*j+1] <= pmul(hi_part(mx_c[j]), lo_part(my_c[j]));
        pp4_q[4*j+2] <= pmul(lo_part(mx_c[j]), hi_part(my_c[j]));
        pp4_q[4*j+3] <= pmul(lo_part(mx_c[j]), lo_part(my_c[j]));
      end
      a4_q   <= a3_q;
      b4_q   <= b3_q;
      c4_q   <= c3_q;
      d4_q   <= d3_q;
      e4_q   <= e3_q;
      vec4_q <= vec3_q;
      uz4_q  <= uz3_q;
      vz4_q  <= vz3_q;

      ac5_q  <= pjoin(pp4_q[0], pp4_q[1], pp4_q[2], pp4_q[3]);
      bb5_q  <= pjoin(pp4_q[4], pp4_q[5], pp4_q[6], pp4_q[7]);
      dc5_q  <= pjoin(pp4_q[8], pp4_q[9], pp4_q[10], pp4_q[11]);
      eb5_q  <= pjoin(pp4_q[12], pp4_q[13], pp4_q[14], pp4_q[15]);
      a5_q   <= a4_q;
      b5_q   <= b4_q;
      c5_q   <= c4_q;
      d5_q   <= d4_q;
      e5_q   <= e4_q;
      vec5_q <= vec4_q;
      uz5_q  <= uz4_q;
      vz5_q  <= vz4_q;

      res_q.a   <= a5_q;
      res_q.b   <= b5_q;
      res_q.c   <= c5_q;
      res_q.d   <= d5_q;
      res_q.e   <= e5_q;
      res_q.den <= ac5_q - bb5_q;
      res_q.num <= dc5_q - eb5_q;
      res_q.vec <= vec5_q;
      res_q.uz  <= uz5_q;
      res_q.vz  <= vz5_q;
    end
  end

  assign res_o = res_q;

endmodule

[design/segment_segment_closest_points.sv]
// closest points of two 3-D segments, one pair per request
//
// input channel: in_valid_i / in_ready_o with the twelve end point
// coordinates in signed Q16.16. output channel: out_valid_o / out_ready_i
// with the clamped parameters, the distance, the unit direction between
// the closest points and the degenerate flag.
//
// the pipeline is a dot and wide product front end, three layers of
// restoring dividers of FRAC_BITS + 1 stages each (first parameter;
// second parameter and recomputed first parameter; direction, one per
// axis), a 38-stage square root and selection, product, rounding,
// squaring, sum and output registers. a new request is taken in every
// cycle unless the output is held, so throughput is one pair per cycle.
//
// when the receiver holds out_ready_i low with a result waiting, the whole
// pipeline holds and in_ready_o drops; nothing is lost or repeated.
// reset clears the valid bits only; the pipeline is empty afterwards.
module segment_segment_closest_points #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sscp_pkg::IN_W-1:0]   first_start_x_i,
  input  logic [sscp_pkg::IN_W-1:0]   first_start_y_i,
  input  logic [sscp_pkg::IN_W-1:0]   first_start_z_i,
  input  logic [sscp_pkg::IN_W-1:0]   first_end_x_i,
  input  logic [sscp_pkg::IN_W-1:0]   first_end_y_i,
  input  logic [sscp_pkg::IN_W-1:0]   first_end_z_i,
  input  logic [sscp_pkg::IN_W-1:0]   second_start_x_i,
  input  logic [sscp_pkg::IN_W-1:0]   second_start_y_i,
  input  logic [sscp_pkg::IN_W-1:0]   second_start_z_i,
  input  logic [sscp_pkg::IN_W-1:0]   second_end_x_i,
  input  logic [sscp_pkg::IN_W-1:0]   second_end_y_i,
  input  logic [sscp_pkg::IN_W-1:0]   second_end_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [FRAC_BITS:0]          first_param_o,
  output logic [FRAC_BITS:0]          second_param_o,
  output logic [sscp_pkg::DIST_W-1:0] closest_distance_o,
  output logic signed [FRAC_BITS+1:0] dir_x_o,
  output logic signed [FRAC_BITS+1:0] dir_y_o,
  output logic signed [FRAC_BITS+1:0] dir_z_o,
  output logic                        degenerate_o
);

  import sscp_pkg::*;

  localparam int unsigned PW    = FRAC_BITS + 1;
  localparam int unsigned XW    = FRAC_BITS + 36;
  localparam int unsigned DV_W  = ROOT_W + 1;
  localparam int unsigned DEPTH = 3 * FRAC_BITS + 54;
  localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [DOT_W-1:0] a;
    logic [DOT_W-1:0] b;
    logic [DOT_W-1:0] c;
    logic [DOT_W-1:0] d;
    logic [DOT_W-1:0] e;
    logic             den_zero;
  } dots_t;

  typedef struct packed {
    vecs_t vec;
    logic  uz;
    logic  vz;
  } tail_t;

  typedef struct packed {
    logic          recompute;
    logic [PW-1:0] uf;
    logic          a0;
    logic [PW-1:0] sc;
  } sel_t;

  typedef struct packed {
    logic [2:0][PD_W-1:0] pd;
    logic                 uz;
    logic                 vz;
    logic [PW-1:0]        sc;
    logic [PW-1:0]        tc;
  } geo_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic [DIST_W-1:0] dlen;
    logic              degen;
    logic [PW-1:0]     sc;
    logic [PW-1:0]     tc;
  } fin_t;

  logic   en;
  logic   [DEPTH-1:0] vld_q;
  logic   out_valid_q;
  pts_t   pts;
  front_t fr;

  logic [PW-1:0] sc1;
  dots_t         dots_in, dots_d1;
  tail_t         tail_in, tail_dl;

  logic signed [WIDE_W-1:0] a_w, b_w, c_w, d_w, e_w, scb;
  logic [PW-1:0]            sc_eff;
  logic signed [WIDE_W-1:0] numt1_q, dent1_q, numr0_q, numr1_q, denr1_q;
  logic [PW-1:0]            sce1_q;
  logic                     c0_q, a01_q;

  logic                     neg_t, gt_t;
  logic signed [WIDE_W-1:0] numt2_q, dent2_q, numr2_q, denr2_q;
  sel_t                     sel2_q, sel_dl;

  logic [PW-1:0] q_tc, q_sr;

  logic [PW-1:0]            sc0_q, tc0_q;
  tail_t                    tl0_q;
  logic signed [XW-1:0]     m1_q [3];
  logic signed [XW-1:0]     m2_q [3];
  logic signed [XW-1:0]     m3_q [3];
  logic                     uz1_q, vz1_q, uz2_q, vz2_q, uz3_q, vz3_q;
  logic [PW-1:0]            sc1_q, tc1_q, sc2_q, tc2_q, sc3_q, tc3_q;
  logic signed [XW-1:0]     x_c [3];
  logic [XW-1:0]            mag_c [3];
  logic [XW-1:0]            magr_c [3];
  logic signed [PD_W-1:0]   pd2_q [3];
  logic signed [PD_W-1:0]   pd3_q [3];
  logic [2*PD_W-1:0]        sq3_q [3];
  logic [SUM_W-1:0]         sum4_q;
  geo_t                     geo4_q, geo_dl;

  logic [ROOT_W-1:0]  root;
  logic [PD_W-1:0]    pmag [3];
  logic [PW-1:0]      dq [3];
  fin_t               fin_in, fin_dl;

  logic [PW-1:0]               sc_out_q, tc_out_q;
  logic [DIST_W-1:0]           dist_out_q;
  logic signed [FRAC_BITS+1:0] dx_q, dy_q, dz_q;
  logic                        degen_out_q;

  // the whole pipeline advances unless a finished result is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign pts = {second_end_z_i, second_end_y_i, second_end_x_i,
                second_start_z_i, second_start_y_i, second_start_x_i,
                first_end_z_i, first_end_y_i, first_end_x_i,
                first_start_z_i, first_start_y_i, first_start_x_i};

  sscp_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .pts_i (pts),
    .res_o (fr)
  );

  // first parameter from the 2x2 solve
  sscp_qdiv #(.W(WIDE_W), .FB(FRAC_BITS)) u_div_sc (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (fr.num),
    .den_i (fr.den),
    .q_o   (sc1)
  );

  assign dots_in = '{a: fr.a, b: fr.b, c: fr.c, d: fr.d, e: fr.e,
                     den_zero: (fr.den == '0)};
  assign tail_in = '{vec: fr.vec, uz: fr.uz, vz: fr.vz};

  sscp_delay #(.W($bits(dots_t)), .D(FRAC_BITS + 1)) u_dly_dots (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dots_in),
    .q_o   (dots_d1)
  );

  sscp_delay #(.W($bits(tail_t)), .D(2 * FRAC_BITS + 4)) u_dly_tail (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (tail_in),
    .q_o   (tail_dl)
  );

  // second parameter setup and recompute operands for the first parameter
  always_comb begin
    a_w    = $signed(dots_d1.a);
    b_w    = $signed(dots_d1.b);
    c_w    = $signed(dots_d1.c);
    d_w    = $signed(dots_d1.d);
    e_w    = $signed(dots_d1.e);
    sc_eff = dots_d1.den_zero ? '0 : sc1;
    scb    = $signed({1'b0, sc_eff}) * b_w;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numt1_q <= dots_d1.den_zero ? -e_w : scb - (e_w <<< FRAC_BITS);
      dent1_q <= dots_d1.den_zero ? c_w : (c_w <<< FRAC_BITS);
      numr0_q <= d_w <<< FRAC_BITS;
      numr1_q <= (b_w <<< FRAC_BITS) + (d_w <<< FRAC_BITS);
      denr1_q <= a_w <<< FRAC_BITS;
      sce1_q  <= sc_eff;
      c0_q    <= (dots_d1.c == '0);
      a01_q   <= (dots_d1.a == '0);
    end
  end

  // clamp test on the second parameter, choice of the recompute numerator
  assign neg_t = (numt1_q < 0);
  assign gt_t  = (numt1_q > dent1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      numt2_q          <= numt1_q;
      dent2_q          <= dent1_q;
      numr2_q          <= (!c0_q && !neg_t && gt_t) ? numr1_q : numr0_q;
      denr2_q          <= denr1_q;
      sel2_q.recompute <= c0_q || neg_t || gt_t;
      sel2_q.uf        <= (!c0_q && !neg_t && gt_t) ? ONE : '0;
      sel2_q.a0        <= a01_q;
      sel2_q.sc        <= sce1_q;
    end
  end

  sscp_qdiv #(.W(WIDE_W), .FB(FRAC_BITS)) u_div_tc (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numt2_q),
    .den_i (dent2_q),
    .q_o   (q_tc)
  );

  sscp_qdiv #(.W(WIDE_W), .FB(FRAC_BITS)) u_div_sr (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numr2_q),
    .den_i (denr2_q),
    .q_o   (q_sr)
  );

  sscp_delay #(.W($bits(sel_t)), .D(FRAC_BITS + 1)) u_dly_sel (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sel2_q),
    .q_o   (sel_dl)
  );

  // parameter selection, difference vector, rounding, squared length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_c[i]    = m1_q[i] - m2_q[i] - m3_q[i];
      mag_c[i]  = x_c[i][XW-1] ? XW'(-x_c[i]) : XW'(x_c[i]);
      magr_c[i] = (mag_c[i] + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc0_q <= sel_dl.recompute ? (sel_dl.a0 ? '0 : q_sr) : sel_dl.sc;
      tc0_q <= sel_dl.recompute ? sel_dl.uf : q_tc;
      tl0_q <= tail_dl;

      for (int i = 0; i < 3; i++) begin
        m1_q[i] <= $signed(tl0_q.vec[i]) * $signed({1'b0, sc0_q});
        m2_q[i] <= $signed(tl0_q.vec[3+i]) * $signed({1'b0, tc0_q});
        m3_q[i] <= XW'($signed(tl0_q.vec[6+i])) <<< FRAC_BITS;
      end
      uz1_q <= tl0_q.uz;
      vz1_q <= tl0_q.vz;
      sc1_q <= sc0_q;
      tc1_q <= tc0_q;

      for (int i = 0; i < 3; i++) begin
        pd2_q[i] <= x_c[i][XW-1] ? -$signed(PD_W'(magr_c[i])) : $signed(PD_W'(magr_c[i]));
      end
      uz2_q <= uz1_q;
      vz2_q <= vz1_q;
      sc2_q <= sc1_q;
      tc2_q <= tc1_q;

      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= pd2_q[i] * pd2_q[i];
        pd3_q[i] <= pd2_q[i];
      end
      uz3_q <= uz2_q;
      vz3_q <= vz2_q;
      sc3_q <= sc2_q;
      tc3_q <= tc2_q;

      sum4_q <= SUM_W'(sq3_q[0]) + SUM_W'(sq3_q[1]) + SUM_W'(sq3_q[2]);
      for (int i = 0; i < 3; i++) begin
        geo4_q.pd[i] <= pd3_q[i];
      end
      geo4_q.uz <= uz3_q;
      geo4_q.vz <= vz3_q;
      geo4_q.sc <= sc3_q;
      geo4_q.tc <= tc3_q;
    end
  end

  sscp_isqrt #(.SW(SUM_W), .RW(ROOT_W)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum4_q),
    .root_o (root)
  );

  sscp_delay #(.W($bits(geo_t)), .D(ROOT_W)) u_dly_geo (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (geo4_q),
    .q_o   (geo_dl)
  );

  // direction, one divider per axis
  for (genvar i = 0; i < 3; i++) begin : g_dir
    assign pmag[i] = geo_dl.pd[i][PD_W-1] ? PD_W'(-$signed(geo_dl.pd[i])) : geo_dl.pd[i];
    sscp_qdiv #(.W(DV_W), .FB(FRAC_BITS)) u_div_dir (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ($signed(DV_W'(pmag[i]))),
      .den_i ($signed(DV_W'(root))),
      .q_o   (dq[i])
    );
    assign fin_in.neg[i] = geo_dl.pd[i][PD_W-1];
  end

  assign fin_in.dlen  = (root > DIST_MAX) ? DIST_W'(DIST_MAX) : root[DIST_W-1:0];
  assign fin_in.degen = geo_dl.uz || geo_dl.vz || (root == '0);
  assign fin_in.sc    = geo_dl.sc;
  assign fin_in.tc    = geo_dl.tc;

  sscp_delay #(.W($bits(fin_t)), .D(FRAC_BITS + 1)) u_dly_fin (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (fin_in),
    .q_o   (fin_dl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[DEPTH-2:0], in_valid_i};
      out_valid_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_out_q    <= fin_dl.sc;
      tc_out_q    <= fin_dl.tc;
      dist_out_q  <= fin_dl.dlen;
      degen_out_q <= fin_dl.degen;
      dx_q <= fin_dl.degen ? '0 : fin_dl.neg[0] ? -$signed({1'b0, dq[0]}) : $signed({1'b0, dq[0]});
      dy_q <= fin_dl.degen ? '0 : fin_dl.neg[1] ? -$signed({1'b0, dq[1]}) : $signed({1'b0, dq[1]});
      dz_q <= fin_dl.degen ? '0 : fin_dl.neg[2] ? -$signed({1'b0, dq[2]}) : $signed({1'b0, dq[2]});
    end
  end

  assign out_valid_o        = out_valid_q;
  assign first_param_o      = sc_out_q;
  assign second_param_o     = tc_out_q;
  assign closest_distance_o = dist_out_q;
  assign dir_x_o            = dx_q;
  assign dir_y_o            = dy_q;
  assign dir_z_o            = dz_q;
  assign degenerate_o       = degen_out_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request not in pipeline");

  a_params_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_param_o <= ONE) && (second_param_o <= ONE))
    else $error("parameter above one");

  a_degen_zero_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> (dir_x_o == 0) && (dir_y_o == 0) && (dir_z_o == 0))
    else $error("degenerate result with nonzero direction");

endmodule
